// ===== rtl/core/erwt_pkg.sv =====
`timescale 1ns / 1ps

package erwt_pkg;

    localparam int CFG_W      = 7;
    localparam int THR_W      = 17;
    localparam int WEIGHT_W   = 17;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    localparam int MAX_LENGTH_DEF = 64;

    localparam int DVD_W     = CFG_W + WEIGHT_W;
    localparam int DVS_W     = CFG_W + 1;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_COUNT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD   = 3'd4;

    localparam logic [CFG_W-1:0] PATTERN_LENGTH_RST   = 7'd16;
    localparam logic [CFG_W-1:0] REFERENCE_LENGTH_RST = 7'd16;
    localparam logic [CFG_W-1:0] BEAT_COUNT_RST       = 7'd4;
    localparam logic [THR_W-1:0] LOW_THRESHOLD_RST    = 17'd32768;
    localparam logic [THR_W-1:0] HIGH_THRESHOLD_RST   = 17'd32768;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ===== rtl/core/erwt_ram.sv =====
`timescale 1ns / 1ps

module erwt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/erwt_div.sv =====
`timescale 1ns / 1ps

module erwt_div
    import erwt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       diff;
    logic                 take;
    logic [DVS_W-1:0]     n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        take    = (shifted >= {1'b0, r_dvs});
        n_rem   = take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= DIV_CNT_W'(DVD_W - 1);
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_quo <= {r_quo[DVD_W-2:0], take};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== rtl/core/euclidean_rhythm_weighted_trigger_top.sv =====
`timescale 1ns / 1ps
// An item goes S_EDGE, S_READ, S_RESULT to o_out_valid; the next waits for S_IDLE.
// An edge that wraps a shortened pattern adds a modulo (S_MOD) in the shared divider.
// A change in clamped pattern or reference length or beat count rebuilds the table:
// clear all MAX_LENGTH entries, then three 24-bit divisions per beat in the divider.
// Synchronous active-low reset: registers to defaults, no edge seen, rebuild pending.

module euclidean_rhythm_weighted_trigger_top
    import erwt_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_clock_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_low_trigger,
    output logic                  o_high_trigger,
    output logic                  o_bar_start,
    output logic [WEIGHT_W-1:0]   o_step_weight,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_LENGTH);
    localparam int CW = ((IW > CFG_W) ? IW : CFG_W) + 2;
    localparam int QW = 2 * CFG_W;
    localparam int RW = WEIGHT_W + 1;
    localparam int KW = 3 * CFG_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CLEAR  = 10'b0000000010,
        S_BEAT   = 10'b0000000100,
        S_DIVQ   = 10'b0000001000,
        S_DIVR   = 10'b0000010000,
        S_DIVW   = 10'b0000100000,
        S_EDGE   = 10'b0001000000,
        S_MOD    = 10'b0010000000,
        S_READ   = 10'b0100000000,
        S_RESULT = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_pattern_length;
    logic [CFG_W-1:0] r_reference_length;
    logic [CFG_W-1:0] r_beat_count;
    logic [THR_W-1:0] r_low_threshold;
    logic [THR_W-1:0] r_high_threshold;

    logic [CFG_W-1:0] len_c, ref_c, beats_c;
    logic             rebuild;

    logic [CFG_W-1:0] r_len, r_ref, r_beats;
    logic [KW-1:0]    r_built_key;
    logic             r_built_valid;

    logic [IW-1:0]    r_addr;
    logic [CFG_W-1:0] r_beat;
    logic [QW-1:0]    r_nacc, r_racc, r_q;

    logic [IW-1:0]    r_step;
    logic             r_step_valid;
    logic             r_last_pos;
    logic             r_edge;

    logic             r_out_valid;
    logic             r_low, r_high, r_bar;
    logic [WEIGHT_W-1:0] r_weight;

    logic             positive;
    logic [CW-1:0]    inc, len_w, inc_sub;
    logic [DVS_W:0]   twice_rem, beats_w;
    logic             round_up;
    logic [QW-1:0]    q_next;
    logic [CFG_W-1:0] rr, rr_c, m, wdiff;
    logic [DVD_W-1:0] w_num;
    logic             last_beat;
    logic             hit_ok;
    logic             out_free;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr;
    logic [RW-1:0]    ram_wdata, ram_rdata;
    logic             rd_hit;
    logic [WEIGHT_W-1:0] rd_weight;

    erwt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    erwt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_LENGTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_step),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        if (r_pattern_length == '0) begin
            len_c = CFG_W'(1);
        end else if (int'(r_pattern_length) > MAX_LENGTH) begin
            len_c = CFG_W'(MAX_LENGTH);
        end else begin
            len_c = r_pattern_length;
        end
        if (r_reference_length == '0) begin
            ref_c = CFG_W'(1);
        end else if (int'(r_reference_length) > MAX_LENGTH) begin
            ref_c = CFG_W'(MAX_LENGTH);
        end else begin
            ref_c = r_reference_length;
        end
        if (r_beat_count == '0) begin
            beats_c = CFG_W'(1);
        end else if (r_beat_count > len_c) begin
            beats_c = len_c;
        end else begin
            beats_c = r_beat_count;
        end
        rebuild = !r_built_valid || ({len_c, ref_c, beats_c} != r_built_key);
    end

    always_comb begin
        positive  = !i_clock_sample[SAMPLE_W-1] && (|i_clock_sample);
        inc       = CW'(r_step) + CW'(1);
        len_w     = CW'(r_len);
        inc_sub   = inc - len_w;
        twice_rem = {div_rsp.remainder, 1'b0};
        beats_w   = (DVS_W + 1)'(r_beats);
        round_up  = (twice_rem > beats_w) ||
                    ((twice_rem == beats_w) && div_rsp.quotient[0]);
        q_next    = QW'(div_rsp.quotient) + QW'(round_up);
        rr        = CFG_W'(div_rsp.remainder);
        rr_c      = r_beats - rr;
        m         = (rr < rr_c) ? rr : rr_c;
        wdiff     = r_beats - CFG_W'({m, 1'b0});
        w_num     = {wdiff, {WEIGHT_W{1'b0}}} + DVD_W'(r_beats);
        last_beat = (CFG_W'(r_beat + CFG_W'(1)) == r_beats);
        hit_ok    = (r_q < QW'(r_len));
        out_free  = !r_out_valid || i_out_ready;
        rd_hit    = ram_rdata[WEIGHT_W];
        rd_weight = ram_rdata[WEIGHT_W-1:0];
    end

    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        ram_we           = 1'b0;
        ram_waddr        = r_addr;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rebuild ? S_CLEAR : S_EDGE;
                end
            end
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == IW'(MAX_LENGTH - 1)) begin
                    n_state = S_BEAT;
                end
            end
            S_BEAT: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(r_nacc);
                div_req.divisor  = DVS_W'(r_beats);
                n_state          = S_DIVQ;
            end
            S_DIVQ: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(r_racc);
                    div_req.divisor  = DVS_W'(r_beats);
                    n_state          = S_DIVR;
                end
            end
            S_DIVR: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = w_num;
                    div_req.divisor  = {r_beats, 1'b0};
                    n_state          = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    ram_we    = hit_ok;
                    ram_waddr = IW'(r_q);
                    ram_wdata = {1'b1, WEIGHT_W'(div_rsp.quotient)};
                    n_state   = last_beat ? S_EDGE : S_BEAT;
                end
            end
            S_EDGE: begin
                n_state = S_READ;
                if (r_edge && r_step_valid && (inc >= len_w) && (inc_sub >= len_w)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(inc);
                    div_req.divisor  = DVS_W'(r_len);
                    n_state          = S_MOD;
                end
            end
            S_MOD: begin
                if (div_rsp.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_pattern_length   <= PATTERN_LENGTH_RST;
            r_reference_length <= REFERENCE_LENGTH_RST;
            r_beat_count       <= BEAT_COUNT_RST;
            r_low_threshold    <= LOW_THRESHOLD_RST;
            r_high_threshold   <= HIGH_THRESHOLD_RST;
            r_built_valid      <= 1'b0;
            r_step             <= '0;
            r_step_valid       <= 1'b0;
            r_last_pos         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PATTERN_LENGTH:   r_pattern_length   <= i_cfg_data[CFG_W-1:0];
                    REG_REFERENCE_LENGTH: r_reference_length <= i_cfg_data[CFG_W-1:0];
                    REG_BEAT_COUNT:       r_beat_count       <= i_cfg_data[CFG_W-1:0];
                    REG_LOW_THRESHOLD:    r_low_threshold    <= i_cfg_data[THR_W-1:0];
                    REG_HIGH_THRESHOLD:   r_high_threshold   <= i_cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_IDLE) && i_in_valid) begin
                r_last_pos <= positive;
            end
            if ((r_state == S_DIVW) && div_rsp.done && last_beat) begin
                r_built_valid <= 1'b1;
            end
            if ((r_state == S_EDGE) && r_edge) begin
                r_step_valid <= 1'b1;
                if (!r_step_valid) begin
                    r_step <= '0;
                end else if (inc < len_w) begin
                    r_step <= IW'(inc);
                end else if (inc_sub < len_w) begin
                    r_step <= IW'(inc_sub);
                end
            end
            if ((r_state == S_MOD) && div_rsp.done) begin
                r_step <= IW'(div_rsp.remainder);
            end
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_edge  <= positive && !r_last_pos;
            r_len   <= len_c;
            r_ref   <= ref_c;
            r_beats <= beats_c;
            r_addr  <= '0;
            r_beat  <= '0;
            r_nacc  <= '0;
            r_racc  <= '0;
        end
        if (r_state == S_CLEAR) begin
            r_addr <= r_addr + IW'(1);
        end
        if ((r_state == S_DIVQ) && div_rsp.done) begin
            r_q <= q_next;
        end
        if ((r_state == S_DIVW) && div_rsp.done) begin
            r_beat <= r_beat + CFG_W'(1);
            r_nacc <= r_nacc + QW'(r_len);
            r_racc <= r_racc + QW'(r_ref);
            if (last_beat) begin
                r_built_key <= {r_len, r_ref, r_beats};
            end
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_low    <= r_edge && rd_hit && (rd_weight < r_low_threshold);
            r_high   <= r_edge && rd_hit && (rd_weight >= r_high_threshold);
            r_bar    <= r_edge && (r_step == '0);
            r_weight <= r_step_valid ? rd_weight : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_low_trigger  = r_low;
    assign o_high_trigger = r_high;
    assign o_bar_start    = r_bar;
    assign o_step_weight  = r_weight;

endmodule
